### rtl/core/gnhf_pkg.sv
// Shared constants, codes and helper functions of the no-data hole fill grid store.
package gnhf_pkg;

  // Cell and grid geometry.
  localparam int CELL_W   = 40;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int SIZE_W   = 7;
  localparam int TOL_W    = 16;
  localparam int CIDX_W   = 3;

  // Register reset values.
  localparam logic signed [CELL_W-1:0] NODATA_RESET = -40'sd6553534464;
  localparam logic signed [CELL_W-1:0] GAIN_RESET   = 40'sd65536;
  localparam logic [TOL_W-1:0]         TOL_RESET    = 16'd7;
  localparam logic [SIZE_W-1:0]        SIZE_RESET   = 7'd64;

  // Request function codes.
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_NODATA = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_GAIN   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_OFFSET = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_TOL    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_SMOOTH = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ROWS   = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_COLS   = 3'd6;

  // Absolute difference of two cells; it always fits in one extra bit.
  function automatic logic [CELL_W:0] abs_diff(input logic signed [CELL_W-1:0] a,
                                               input logic signed [CELL_W-1:0] b);
    logic signed [CELL_W:0] d;
    d = {a[CELL_W-1], a} - {b[CELL_W-1], b};
    return d[CELL_W] ? (~d + 1'b1) : d;
  endfunction

  // Address of neighbor k around window center (ii, jj).
  function automatic logic [ADDR_W-1:0] nb_addr(input logic [ROW_W-1:0] ii,
                                                input logic [COL_W-1:0] jj,
                                                input logic [2:0] k);
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    case (k)
      3'd0, 3'd1, 3'd2: r = ii + 1'b1;
      3'd3, 3'd4:       r = ii;
      default:          r = ii - 1'b1;
    endcase
    case (k)
      3'd0, 3'd3, 3'd5: c = jj - 1'b1;
      3'd1, 3'd6:       c = jj;
      default:          c = jj + 1'b1;
    endcase
    return {r, c};
  endfunction

endpackage

### rtl/core/grid_nodata_hole_fill.sv
// Grid store of Q24.16 cells with scaled writes and no-data hole filling on read.
//
// A 64x64 grid of 40-bit cells held in one single-port-read, single-port-write
// memory with a registered read. Requests are handled one at a time; the
// cost of a request is set by the memory accesses and by two bit-serial units.
// A write of the no-data marker is stored as it is accepted; any other write
// runs the shift-add multiplier, then rounding and the saturating offset add.
// A read of a valid cell, or with smoothing off, fetches the center cell and
// goes to the output register; a filled read adds the eight neighbor fetches
// and the bit-serial floor division of the neighbor sum.
// A clear sweeps the memory one cell a cycle. After reset the same sweep runs
// before the first request is taken; configuration writes are taken at all
// times. A finished read waits in the output register, so the next request is
// accepted while the previous result is still stalled.
module grid_nodata_hole_fill
  import gnhf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [ROW_W-1:0]         in_row_index,
  input  logic [COL_W-1:0]         in_col_index,
  input  logic signed [CELL_W-1:0] in_sample_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CELL_W-1:0] out_cell_value,
  output logic                     out_was_filled,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CELL_W-1:0]        cfg_data
);

  localparam int PROD_W = 2 * CELL_W;
  localparam int SUM_W  = CELL_W + 3;
  localparam int NUM_W  = SUM_W + 2;
  localparam int DIV_W  = NUM_W + 1;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_CLEAR  = 13'b0000000000010,
    ST_MUL    = 13'b0000000000100,
    ST_RND    = 13'b0000000001000,
    ST_WR     = 13'b0000000010000,
    ST_CFETCH = 13'b0000000100000,
    ST_CTR    = 13'b0000001000000,
    ST_NFETCH = 13'b0000010000000,
    ST_NACC   = 13'b0000100000000,
    ST_DPREP  = 13'b0001000000000,
    ST_DIV    = 13'b0010000000000,
    ST_FIN    = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [CELL_W-1:0] nodata_r, gain_r, offset_r;
  logic [TOL_W-1:0]         tol_r;
  logic                     smooth_r;
  logic [SIZE_W-1:0]        rows_r, cols_r;

  // Sweep, multiplier, neighbor and divider working registers.
  logic [ADDR_W-1:0]        clr_cnt_r;
  logic signed [CELL_W-1:0] clr_val_r;
  logic [ADDR_W-1:0]        wr_addr_r, rd_addr_r;
  logic signed [CELL_W-1:0] rd_data_r;
  logic [CELL_W-1:0]        ma_r, mb_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        acc_r;
  logic [5:0]               cnt_r;
  logic signed [CELL_W:0]   prod_r;
  logic [ROW_W-1:0]         ii_r;
  logic [COL_W-1:0]         jj_r;
  logic [2:0]               nb_r;
  logic [3:0]               np_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [DIV_W-1:0]         dvd_r;
  logic [3:0]               rem_r;
  logic [4:0]               dsor_r;
  logic                     dneg_r;
  logic signed [CELL_W-1:0] res_r;
  logic                     filled_r;
  logic                     out_valid_r;
  logic signed [CELL_W-1:0] out_value_r;
  logic                     out_filled_r;

  // Cell memory.
  logic [CELL_W-1:0]        cell_mem [DEPTH];
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [CELL_W-1:0]        mem_wdata;

  logic                     in_accept;
  logic [SIZE_W-1:0]        rows_eff, cols_eff;
  logic                     in_grid;
  logic [SIZE_W-1:0]        ii_w, jj_w;
  logic                     rd_valid;
  logic                     out_free;
  logic [PROD_W:0]          rnd_sum;
  logic [PROD_W-CELL_W+24:0] rnd_mag;
  logic [PROD_W-CELL_W+24:0] rnd_lim;
  logic [CELL_W-1:0]        rnd_sat;
  logic signed [CELL_W+1:0] ofs_sum;
  logic signed [CELL_W-1:0] ofs_sat;
  logic signed [NUM_W-1:0]  num_w;
  logic [DIV_W-1:0]         num_ext;
  logic [4:0]               div_t;
  logic                     div_ge;
  logic [DIV_W-1:0]         quo_w;
  logic signed [CELL_W-1:0] mean_w;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_was_filled = out_filled_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Grid size clamped to the supported range.
  always_comb begin
    rows_eff = (rows_r < 7'd3) ? 7'd3 : ((rows_r > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_r);
    cols_eff = (cols_r < 7'd3) ? 7'd3 : ((cols_r > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_r);
    in_grid  = ({1'b0, in_row_index} < rows_eff) && ({1'b0, in_col_index} < cols_eff);
    // Window center moves inward at the grid edges.
    if (in_row_index == '0) begin
      ii_w = 7'd1;
    end else if ({1'b0, in_row_index} == rows_eff - 7'd1) begin
      ii_w = rows_eff - 7'd2;
    end else begin
      ii_w = {1'b0, in_row_index};
    end
    if (in_col_index == '0) begin
      jj_w = 7'd1;
    end else if ({1'b0, in_col_index} == cols_eff - 7'd1) begin
      jj_w = cols_eff - 7'd2;
    end else begin
      jj_w = {1'b0, in_col_index};
    end
  end

  assign rd_valid = abs_diff(rd_data_r, nodata_r) > {{(CELL_W+1-TOL_W){1'b0}}, tol_r};

  // Rounding and saturation of the product magnitude.
  always_comb begin
    rnd_sum = {1'b0, acc_r} + (PROD_W+1)'(17'h08000);
    rnd_mag = rnd_sum[PROD_W:16];
    rnd_lim = neg_r ? (PROD_W-CELL_W+25)'(40'h8000000000)
                    : (PROD_W-CELL_W+25)'(40'h7fffffffff);
    rnd_sat = (rnd_mag > rnd_lim) ? rnd_lim[CELL_W-1:0] : rnd_mag[CELL_W-1:0];
  end

  // Saturating offset add.
  always_comb begin
    ofs_sum = {prod_r[CELL_W], prod_r} + {{2{offset_r[CELL_W-1]}}, offset_r};
    if (ofs_sum > (CELL_W+2)'(40'sh7fffffffff)) begin
      ofs_sat = {1'b0, {(CELL_W-1){1'b1}}};
    end else if (ofs_sum < -(CELL_W+2)'(41'sh08000000000)) begin
      ofs_sat = {1'b1, {(CELL_W-1){1'b0}}};
    end else begin
      ofs_sat = ofs_sum[CELL_W-1:0];
    end
  end

  // Division setup: numerator 2*sum + n, negated and biased for a floor quotient.
  always_comb begin
    num_w   = {sum_r[SUM_W-1], sum_r, 1'b0} + {{(NUM_W-4){1'b0}}, np_r};
    num_ext = {num_w[NUM_W-1], num_w};
    div_t   = {rem_r, dvd_r[DIV_W-1]};
    div_ge  = (div_t >= dsor_r);
    quo_w   = dneg_r ? (~dvd_r + 1'b1) : dvd_r;
    mean_w  = quo_w[CELL_W-1:0];
  end

  // Memory write port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_r;
    mem_wdata = ofs_sat;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = clr_val_r;
    end else if (state_r == ST_WR) begin
      mem_we    = 1'b1;
    end else if (in_accept && in_func == FN_WRITE && in_grid && in_sample_value == nodata_r) begin
      mem_we    = 1'b1;
      mem_waddr = {in_row_index, in_col_index};
      mem_wdata = in_sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= cell_mem[rd_addr_r];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_func)
            FN_WRITE: state_nxt = (in_grid && in_sample_value != nodata_r) ? ST_MUL : ST_IDLE;
            FN_READ:  state_nxt = in_grid ? ST_CFETCH : ST_OUT;
            FN_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:  state_nxt = (clr_cnt_r == ADDR_W'(DEPTH - 1)) ? ST_IDLE : ST_CLEAR;
      ST_MUL:    state_nxt = (cnt_r == 6'd1) ? ST_RND : ST_MUL;
      ST_RND:    state_nxt = ST_WR;
      ST_WR:     state_nxt = ST_IDLE;
      ST_CFETCH: state_nxt = ST_CTR;
      ST_CTR:    state_nxt = (smooth_r && !rd_valid) ? ST_NFETCH : ST_OUT;
      ST_NFETCH: state_nxt = ST_NACC;
      ST_NACC:   state_nxt = (nb_r == 3'd7) ? ST_DPREP : ST_NFETCH;
      ST_DPREP:  state_nxt = (np_r == 4'd0) ? ST_OUT : ST_DIV;
      ST_DIV:    state_nxt = (cnt_r == 6'd1) ? ST_FIN : ST_DIV;
      ST_FIN:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_val_r    <= NODATA_RESET;
      nodata_r     <= NODATA_RESET;
      gain_r       <= GAIN_RESET;
      offset_r     <= '0;
      tol_r        <= TOL_RESET;
      smooth_r     <= 1'b0;
      rows_r       <= SIZE_RESET;
      cols_r       <= SIZE_RESET;
      out_valid_r  <= 1'b0;
      rd_addr_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODATA: nodata_r <= cfg_data;
          CFG_GAIN:   gain_r   <= cfg_data;
          CFG_OFFSET: offset_r <= cfg_data;
          CFG_TOL:    tol_r    <= cfg_data[TOL_W-1:0];
          CFG_SMOOTH: smooth_r <= cfg_data[0];
          CFG_ROWS:   rows_r   <= cfg_data[SIZE_W-1:0];
          CFG_COLS:   cols_r   <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end

      // Output register loads a finished read, else drains when taken.
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            wr_addr_r <= {in_row_index, in_col_index};
            rd_addr_r <= {in_row_index, in_col_index};
            ii_r      <= ii_w[ROW_W-1:0];
            jj_r      <= jj_w[COL_W-1:0];
            ma_r      <= gain_r[CELL_W-1] ? CELL_W'(-gain_r) : CELL_W'(gain_r);
            mb_r      <= in_sample_value[CELL_W-1] ? CELL_W'(-in_sample_value)
                                                   : CELL_W'(in_sample_value);
            neg_r     <= gain_r[CELL_W-1] ^ in_sample_value[CELL_W-1];
            acc_r     <= '0;
            cnt_r     <= 6'(CELL_W);
            clr_cnt_r <= '0;
            clr_val_r <= nodata_r;
            res_r     <= nodata_r;
            filled_r  <= 1'b0;
          end
        end
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
        // Shift-add multiply, one multiplier bit a cycle from the top.
        ST_MUL: begin
          acc_r <= {acc_r[PROD_W-2:0], 1'b0} + (mb_r[CELL_W-1] ? {{CELL_W{1'b0}}, ma_r} : '0);
          mb_r  <= {mb_r[CELL_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
        end
        ST_RND: begin
          prod_r <= neg_r ? -$signed({1'b0, rnd_sat}) : $signed({1'b0, rnd_sat});
        end
        // Center cell is back: return it, or start the neighbor walk.
        ST_CTR: begin
          res_r     <= rd_data_r;
          filled_r  <= 1'b0;
          nb_r      <= '0;
          np_r      <= '0;
          sum_r     <= '0;
          rd_addr_r <= nb_addr(ii_r, jj_r, 3'd0);
        end
        ST_NACC: begin
          if (rd_valid) begin
            np_r  <= np_r + 1'b1;
            sum_r <= sum_r + {{(SUM_W-CELL_W){rd_data_r[CELL_W-1]}}, rd_data_r};
          end
          nb_r      <= nb_r + 1'b1;
          rd_addr_r <= nb_addr(ii_r, jj_r, nb_r + 1'b1);
        end
        ST_DPREP: begin
          res_r  <= nodata_r;
          dneg_r <= num_w[NUM_W-1];
          dsor_r <= {np_r, 1'b0};
          dvd_r  <= num_w[NUM_W-1] ? (~num_ext + {{(DIV_W-5){1'b0}}, np_r, 1'b0})
                                   : num_ext;
          rem_r  <= '0;
          cnt_r  <= 6'(DIV_W);
        end
        // Restoring division, one quotient bit a cycle.
        ST_DIV: begin
          rem_r <= div_ge ? 4'(div_t - dsor_r) : div_t[3:0];
          dvd_r <= {dvd_r[DIV_W-2:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
        end
        ST_FIN: begin
          if (abs_diff(mean_w, nodata_r) < {{(CELL_W+1-TOL_W){1'b0}}, tol_r}) begin
            res_r    <= nodata_r;
            filled_r <= 1'b0;
          end else begin
            res_r    <= mean_w;
            filled_r <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_value_r  <= res_r;
            out_filled_r <= filled_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### dv/gnhf_cell_checker.sv
// Checker that predicts grid store reads and compares them with the block's results.
module gnhf_cell_checker
  import gnhf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [ROW_W-1:0]         in_row_index,
  input  logic [COL_W-1:0]         in_col_index,
  input  logic signed [CELL_W-1:0] in_sample_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [CELL_W-1:0] out_cell_value,
  input  logic                     out_was_filled,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CELL_W-1:0]        cfg_data,
  output int                       mismatches,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [CELL_W-1:0] value;
    logic                     filled;
  } cell_result_t;

  localparam longint CELL_HI = (64'sd1 <<< (CELL_W - 1)) - 1;
  localparam longint CELL_LO = -CELL_HI - 1;

  logic signed [CELL_W-1:0] cell_mem [0:DEPTH-1];
  logic signed [CELL_W-1:0] nodata;
  logic signed [CELL_W-1:0] gain;
  logic signed [CELL_W-1:0] offset;
  logic [TOL_W-1:0]         tol;
  logic                     smooth;
  logic [SIZE_W-1:0]        rows_reg;
  logic [SIZE_W-1:0]        cols_reg;
  cell_result_t             expected_cells[$];

  assign pending = expected_cells.size();

  initial mismatches = 0;

  // Saturate a wide value to the cell range.
  function automatic logic signed [CELL_W-1:0] clamp_cell(input longint v);
    if (v > CELL_HI) return CELL_HI[CELL_W-1:0];
    if (v < CELL_LO) return CELL_LO[CELL_W-1:0];
    return v[CELL_W-1:0];
  endfunction

  function automatic longint cell_dist(input logic signed [CELL_W-1:0] a,
                                       input logic signed [CELL_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic bit cell_valid(input logic signed [CELL_W-1:0] v);
    return cell_dist(v, nodata) > longint'(tol);
  endfunction

  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Gain product rounded half away from zero, then saturating offset add.
  function automatic logic signed [CELL_W-1:0] scale_sample(
      input logic signed [CELL_W-1:0] s);
    logic signed [2*CELL_W-1:0] prod;
    logic [2*CELL_W-1:0]        m;
    logic [2*CELL_W-1:0]        q;
    logic [2*CELL_W-1:0]        lim;
    longint                     qv;
    prod = gain * s;
    m = prod[2*CELL_W-1] ? -prod : prod;
    q = (m + 80'h8000) >> 16;
    lim = prod[2*CELL_W-1] ? (80'd1 << (CELL_W - 1)) : (80'd1 << (CELL_W - 1)) - 1;
    if (q > lim) q = lim;
    qv = q[63:0];
    if (prod[2*CELL_W-1]) qv = -qv;
    return clamp_cell(longint'(clamp_cell(qv)) + longint'(offset));
  endfunction

  function automatic logic signed [CELL_W-1:0] cell_at(input int r, input int c);
    return cell_mem[r * MAX_COLS + c];
  endfunction

  // Read of one cell, with the neighbor mean filling a hole when smoothing is on.
  function automatic cell_result_t predict_read(input int r, input int c);
    cell_result_t             res;
    int                       nr, nc, ii, jj, np;
    longint                   sum, num, den, adj;
    logic signed [CELL_W-1:0] nb [8];
    nr = eff_size(rows_reg, MAX_ROWS);
    nc = eff_size(cols_reg, MAX_COLS);
    res.value = nodata;
    res.filled = 1'b0;
    if (r >= nr || c >= nc) return res;
    res.value = cell_at(r, c);
    if (!smooth || cell_valid(res.value)) return res;
    // The window centre moves inward on the grid border.
    ii = (r == 0) ? 1 : ((r == nr - 1) ? nr - 2 : r);
    jj = (c == 0) ? 1 : ((c == nc - 1) ? nc - 2 : c);
    nb[0] = cell_at(ii + 1, jj - 1); nb[1] = cell_at(ii + 1, jj);
    nb[2] = cell_at(ii + 1, jj + 1); nb[3] = cell_at(ii, jj - 1);
    nb[4] = cell_at(ii, jj + 1);     nb[5] = cell_at(ii - 1, jj - 1);
    nb[6] = cell_at(ii - 1, jj);     nb[7] = cell_at(ii - 1, jj + 1);
    np = 0;
    sum = 0;
    foreach (nb[k]) begin
      if (cell_valid(nb[k])) begin
        np++;
        sum += longint'(nb[k]);
      end
    end
    res.value = nodata;
    if (np == 0) return res;
    // Mean rounded half upward: floor((2*sum + n) / (2*n)).
    num = 2 * sum + np;
    den = 2 * np;
    adj = num / den;
    if ((num % den) != 0 && num < 0) adj--;
    res.value = clamp_cell(adj);
    if (cell_dist(res.value, nodata) < longint'(tol)) res.value = nodata;
    else res.filled = 1'b1;
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Follow the three channels and keep the predicted store in step.
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst_n) begin
      nodata   <= NODATA_RESET;
      gain     <= GAIN_RESET;
      offset   <= '0;
      tol      <= TOL_RESET;
      smooth   <= 1'b0;
      rows_reg <= SIZE_RESET;
      cols_reg <= SIZE_RESET;
      for (int k = 0; k < DEPTH; k++) cell_mem[k] <= NODATA_RESET;
      expected_cells.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          report("result with no request waiting", longint'(out_cell_value), 0);
        end else begin
          want = expected_cells.pop_front();
          if (out_cell_value !== want.value)
            report("cell_value", longint'(out_cell_value), longint'(want.value));
          if (out_was_filled !== want.filled)
            report("was_filled", out_was_filled, want.filled);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODATA: nodata   <= cfg_data;
          CFG_GAIN:   gain     <= cfg_data;
          CFG_OFFSET: offset   <= cfg_data;
          CFG_TOL:    tol      <= cfg_data[TOL_W-1:0];
          CFG_SMOOTH: smooth   <= cfg_data[0];
          CFG_ROWS:   rows_reg <= cfg_data[SIZE_W-1:0];
          CFG_COLS:   cols_reg <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_func)
          FN_WRITE: begin
            if (in_row_index < eff_size(rows_reg, MAX_ROWS) &&
                in_col_index < eff_size(cols_reg, MAX_COLS))
              cell_mem[{in_row_index, in_col_index}] <=
                (in_sample_value == nodata) ? in_sample_value : scale_sample(in_sample_value);
          end
          FN_READ:  expected_cells.push_back(predict_read(in_row_index, in_col_index));
          FN_CLEAR: for (int k = 0; k < DEPTH; k++) cell_mem[k] <= nodata;
          default: ;
        endcase
      end
    end
  end

endmodule

### dv/tb_grid_nodata_hole_fill.sv
// Top of the grid store testbench: clock, reset, requests, configuration and verdict.
module tb_grid_nodata_hole_fill
  import gnhf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        FN_NONE    = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int                IDLE_LIMIT = 20000;
  localparam int                DRAIN_WAIT = 4200;
  localparam longint            CELL_HI    = (64'sd1 <<< (CELL_W - 1)) - 1;
  localparam longint            CELL_LO    = -CELL_HI - 1;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_func = FN_WRITE;
  logic [ROW_W-1:0]         in_row_index = '0;
  logic [COL_W-1:0]         in_col_index = '0;
  logic signed [CELL_W-1:0] in_sample_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CELL_W-1:0] out_cell_value;
  logic                     out_was_filled;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = CFG_NODATA;
  logic [CELL_W-1:0]        cfg_data = '0;
  int                       mismatches;
  int                       pending;

  // Current settings as the stimulus sees them.
  logic signed [CELL_W-1:0] cur_nodata = NODATA_RESET;
  int                       cur_rows = 64;
  int                       cur_cols = 64;
  int                       idle_pct = 25;
  int                       stall_left = 0;
  int                       idle_cycles = 0;

  grid_nodata_hole_fill dut (.*);

  gnhf_cell_checker checker_u (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int clamp_size(input int v);
    return (v < 3) ? 3 : ((v > 64) ? 64 : v);
  endfunction

  function automatic logic [CELL_W-1:0] rand_word();
    return CELL_W'({$urandom, $urandom});
  endfunction

  // One request; waits until the block takes it.
  task automatic send(input logic [1:0] fn, input int r, input int c,
                      input logic signed [CELL_W-1:0] s);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= fn;
    in_row_index    <= ROW_W'(r);
    in_col_index    <= COL_W'(c);
    in_sample_value <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending, wait for all reads to return, then wait the given extra cycles, which can cover a sweep.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CELL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic signed [CELL_W-1:0] nd,
                          input logic signed [CELL_W-1:0] g,
                          input logic signed [CELL_W-1:0] o,
                          input logic [TOL_W-1:0] t, input logic sm,
                          input logic [SIZE_W-1:0] nr, input logic [SIZE_W-1:0] nc);
    cfg_write(CFG_NODATA, nd);
    cfg_write(CFG_GAIN, g);
    cfg_write(CFG_OFFSET, o);
    cfg_write(CFG_TOL, CELL_W'(t));
    cfg_write(CFG_SMOOTH, CELL_W'(sm));
    cfg_write(CFG_ROWS, CELL_W'(nr));
    cfg_write(CFG_COLS, CELL_W'(nc));
    cfg_valid  <= 1'b0;
    cur_nodata = nd;
    cur_rows   = clamp_size(int'(nr));
    cur_cols   = clamp_size(int'(nc));
  endtask

  function automatic logic signed [CELL_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return cur_nodata;
      3:       return cur_nodata + $signed($urandom_range(0, 40)) - 20;
      4:       return CELL_HI[CELL_W-1:0];
      5:       return CELL_LO[CELL_W-1:0];
      6:       return $signed(40'sd65536) * $signed($urandom_range(0, 200)) - 40'sd6553600;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic signed [CELL_W-1:0] pick_extreme(input logic signed [CELL_W-1:0] dflt);
    case ($urandom_range(0, 4))
      0:       return dflt;
      1:       return CELL_HI[CELL_W-1:0];
      2:       return CELL_LO[CELL_W-1:0];
      3:       return $signed(40'(int'($urandom_range(0, 1 << 21)) - (1 << 20)));
      default: return rand_word();
    endcase
  endfunction

  // Random request; most land inside the current grid so holes have neighbors.
  task automatic random_request();
    int          pick;
    int          r;
    int          c;
    logic [1:0]  fn;
    pick = $urandom_range(0, 99);
    fn = (pick < 46) ? FN_WRITE : (pick < 94) ? FN_READ : (pick < 97) ? FN_CLEAR : FN_NONE;
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
    end else begin
      r = $urandom_range(0, cur_rows - 1);
      c = $urandom_range(0, cur_cols - 1);
    end
    send(fn, r, c, pick_sample());
  endtask

  initial begin
    logic [SIZE_W-1:0] nr;
    logic [SIZE_W-1:0] nc;
    logic [TOL_W-1:0]  t;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the full grid with smoothing on.
    set_regs(NODATA_RESET, GAIN_RESET, '0, TOL_RESET, 1'b1, SIZE_RESET, SIZE_RESET);
    cfg_write(CFG_UNUSED, rand_word());
    cfg_valid <= 1'b0;
    send(FN_READ, 0, 0, '0);                      // hole with no valid neighbor
    send(FN_WRITE, 0, 0, CELL_HI[CELL_W-1:0]);
    send(FN_WRITE, 63, 63, CELL_LO[CELL_W-1:0]);
    send(FN_WRITE, 0, 1, NODATA_RESET);           // marker is stored unchanged
    send(FN_WRITE, 1, 1, 40'sd327680);
    send(FN_WRITE, 2, 2, -40'sd98304);
    send(FN_WRITE, 62, 62, 40'sd65537);
    send(FN_READ, 0, 1, '0);                      // top edge, center moves down
    send(FN_READ, 0, 2, '0);
    send(FN_READ, 63, 62, '0);                    // bottom edge
    send(FN_READ, 63, 63, '0);
    send(FN_READ, 0, 0, '0);
    send(FN_READ, 1, 1, '0);
    send(FN_WRITE, 5, 5, NODATA_RESET + 3);       // within tolerance of the marker
    send(FN_READ, 5, 5, '0);
    send(FN_NONE, 1, 1, '0);
    send(FN_READ, 1, 1, '0);
    send(FN_CLEAR, 0, 0, '0);
    send(FN_READ, 0, 0, '0);
    send(FN_READ, 63, 63, '0);

    // Random phases, each with its own settings.
    for (int phase = 0; phase < 8; phase++) begin
      drain(DRAIN_WAIT);
      case (phase)
        0: begin nr = 7'd3; nc = 7'd3; t = 16'd0; end
        1: begin nr = 7'd64; nc = 7'd64; t = 16'hFFFF; end
        2: begin nr = 7'd0; nc = 7'd127; t = TOL_RESET; end
        3: begin nr = 7'd2; nc = 7'd65; t = TOL_W'($urandom_range(0, 65535)); end
        default: begin
          nr = SIZE_W'($urandom_range(3, 8));
          nc = SIZE_W'($urandom_range(3, 8));
          t  = $urandom_range(0, 3) == 0 ? 16'hFFFF : TOL_W'($urandom_range(0, 64));
        end
      endcase
      set_regs(phase == 1 ? CELL_HI[CELL_W-1:0] :
               phase == 2 ? CELL_LO[CELL_W-1:0] : pick_extreme(NODATA_RESET),
               phase == 1 ? CELL_HI[CELL_W-1:0] :
               phase == 2 ? CELL_LO[CELL_W-1:0] : pick_extreme(GAIN_RESET),
               phase == 1 ? CELL_HI[CELL_W-1:0] :
               phase == 2 ? CELL_LO[CELL_W-1:0] : pick_extreme('0),
               t, $urandom_range(0, 4) != 0, nr, nc);
      idle_pct = (phase == 7) ? 0 : ((phase == 5) ? 0 : 25);
      for (int k = 0; k < 48; k++) begin
        // Once, hold the sender back until every read has come back.
        if (phase == 3 && k == 24) drain(0);
        random_request();
      end
    end

    drain(200);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### grid_nodata_hole_fill.f
rtl/core/gnhf_pkg.sv
rtl/core/grid_nodata_hole_fill.sv
dv/gnhf_cell_checker.sv
dv/tb_grid_nodata_hole_fill.sv
